// File: rtl/bfec_pkg.sv
// Shared types and constants of the brace-framed escape codec.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package bfec_pkg;

   // Result slots one input item can expand into, and the width of their count
   localparam int MaxResults = 4;
   localparam int CountWidth = 3;

   // Escape and framing bytes
   localparam logic [7:0] EscByte    = 8'h61;
   localparam logic [7:0] CodeEsc    = 8'h61;
   localparam logic [7:0] CodeSpace  = 8'h62;
   localparam logic [7:0] CodeLBrace = 8'h63;
   localparam logic [7:0] CodeRBrace = 8'h64;
   localparam logic [7:0] SpaceByte  = 8'h20;
   localparam logic [7:0] LBrace     = 8'h7B;
   localparam logic [7:0] RBrace     = 8'h7D;
   localparam logic [7:0] NoCode     = 8'h00;

   // Direction register codes
   localparam logic DirEncode = 1'b0;
   localparam logic DirDecode = 1'b1;

   // Status codes
   localparam logic [1:0] StatusOk     = 2'd0;
   localparam logic [1:0] StatusFrame  = 2'd1;
   localparam logic [1:0] StatusEscape = 2'd2;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       first;
      logic       last;
      logic       has_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_valid;
      logic       end_of_frame;
      logic [1:0] status;
   } rsp_type;

   // One classified item: its results in order and how many there are (1 to 4)
   typedef struct packed {
      logic [CountWidth-1:0]          count;
      rsp_type [MaxResults-1:0]       slots;
   } cmd_type;

   // Escape code for a byte in encode mode, NoCode when it passes unchanged
   function automatic logic [7:0] escape_code(input logic [7:0] b);
      logic [7:0] code;
      unique case (b)
         EscByte:   code = CodeEsc;
         SpaceByte: code = CodeSpace;
         LBrace:    code = CodeLBrace;
         RBrace:    code = CodeRBrace;
         default:   code = NoCode;
      endcase
      return code;
   endfunction

   // Decoded byte for an escape code, with a valid flag in the top bit
   function automatic logic [8:0] unescape_code(input logic [7:0] b);
      logic [8:0] dec;
      unique case (b)
         CodeEsc:    dec = {1'b1, EscByte};
         CodeSpace:  dec = {1'b1, SpaceByte};
         CodeLBrace: dec = {1'b1, LBrace};
         CodeRBrace: dec = {1'b1, RBrace};
         default:    dec = {1'b0, NoCode};
      endcase
      return dec;
   endfunction

   // Keep only the first error of a frame
   function automatic logic [1:0] flag_error(input logic [1:0] cur, input logic [1:0] code);
      return (cur == StatusOk) ? code : cur;
   endfunction

   function automatic rsp_type make_rsp(input logic [7:0] b, input logic valid,
                                        input logic eof, input logic [1:0] st);
      rsp_type r;
      r.out_byte     = b;
      r.out_valid    = valid;
      r.end_of_frame = eof;
      r.status       = st;
      return r;
   endfunction

endpackage

`default_nettype wire

// File: rtl/bfec_front.sv
// Front part of the codec: accepts request beats, tracks frame state and
// expands each item into a command of up to four results. Uses bfec_pkg.
`default_nettype none

module bfec_front import bfec_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    csr_wr_en,
   input  wire logic    csr_wr_data,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   input  wire logic    q_full,
   output logic         push_valid,
   output cmd_type      push_cmd
);

   logic       dir_ff;
   logic       esc_ff, esc_in;
   logic [1:0] err_ff, err_in;
   logic       frame_ff, frame_in;
   logic [CountWidth-1:0] n;
   logic [7:0] code;
   logic [8:0] dec;
   logic       req_accept;

   // Take a beat whenever the queue has room
   assign req_ready  = !q_full;
   assign req_accept = req_valid && req_ready;

   // Classify the item and build its results
   always_comb begin
      esc_in   = esc_ff;
      err_in   = err_ff;
      frame_in = frame_ff;
      push_cmd = '0;
      n        = '0;
      code     = escape_code(req_data.in_byte);
      dec      = unescape_code(req_data.in_byte);
      if (dir_ff == DirEncode) begin
         if (req_data.first) begin
            frame_in = 1'b1;
            push_cmd.slots[n[1:0]] = make_rsp(LBrace, 1'b1, 1'b0, StatusOk);
            n = n + 1'b1;
         end
         if (req_data.has_byte) begin
            if (code != NoCode) begin
               push_cmd.slots[n[1:0]] = make_rsp(EscByte, 1'b1, 1'b0, StatusOk);
               n = n + 1'b1;
               push_cmd.slots[n[1:0]] = make_rsp(code, 1'b1, 1'b0, StatusOk);
               n = n + 1'b1;
            end else begin
               push_cmd.slots[n[1:0]] = make_rsp(req_data.in_byte, 1'b1, 1'b0, StatusOk);
               n = n + 1'b1;
            end
         end
         if (req_data.last) begin
            push_cmd.slots[n[1:0]] = make_rsp(RBrace, 1'b1, 1'b1, StatusOk);
            n = n + 1'b1;
            frame_in = 1'b0;
         end
      end else begin
         priority if (req_data.first) begin
            // open a new frame; the byte must be the opening brace
            esc_in   = 1'b0;
            err_in   = StatusOk;
            frame_in = 1'b1;
            if (!req_data.has_byte || req_data.in_byte != LBrace) begin
               err_in = flag_error(err_in, StatusFrame);
            end
         end else if (req_data.last) begin
            if (!frame_ff) begin
               err_in = flag_error(err_in, StatusFrame);
            end
         end else if (req_data.has_byte) begin
            // content byte; a byte with no open frame opens one
            if (!frame_ff) begin
               err_in   = flag_error(err_in, StatusFrame);
               frame_in = 1'b1;
            end
            if (esc_ff) begin
               esc_in = 1'b0;
               if (dec[8]) begin
                  push_cmd.slots[n[1:0]] = make_rsp(dec[7:0], 1'b1, 1'b0, err_in);
                  n = n + 1'b1;
               end else begin
                  err_in = flag_error(err_in, StatusEscape);
               end
            end else if (req_data.in_byte == EscByte) begin
               esc_in = 1'b1;
            end else begin
               push_cmd.slots[n[1:0]] = make_rsp(req_data.in_byte, 1'b1, 1'b0, err_in);
               n = n + 1'b1;
            end
         end else begin
            // empty middle item: nothing to do
         end
         if (req_data.last) begin
            // close the frame and report its status
            if (req_data.first || !req_data.has_byte || req_data.in_byte != RBrace) begin
               err_in = flag_error(err_in, StatusFrame);
            end
            if (esc_in) begin
               err_in = flag_error(err_in, StatusEscape);
            end
            push_cmd.slots[n[1:0]] = make_rsp(NoCode, 1'b0, 1'b1, err_in);
            n = n + 1'b1;
            esc_in   = 1'b0;
            err_in   = StatusOk;
            frame_in = 1'b0;
         end
      end
      push_cmd.count = n;
   end

   // Drop items that give no result
   assign push_valid = req_accept && (n != '0);

   // Hold direction and frame state; a direction write clears the frame state
   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff   <= DirEncode;
         esc_ff   <= 1'b0;
         err_ff   <= StatusOk;
         frame_ff <= 1'b0;
      end else if (csr_wr_en) begin
         dir_ff   <= csr_wr_data;
         esc_ff   <= 1'b0;
         err_ff   <= StatusOk;
         frame_ff <= 1'b0;
      end else if (req_accept) begin
         esc_ff   <= esc_in;
         err_ff   <= err_in;
         frame_ff <= frame_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/bfec_queue.sv
// Short command queue between the front and back parts of the codec.
// Register based, depth set by parameter. Uses bfec_pkg for the command type.
`default_nettype none

module bfec_queue import bfec_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push_valid,
   input  wire cmd_type push_cmd,
   output logic         q_full,
   input  wire logic    pop,
   output logic         q_empty,
   output cmd_type      head
);

   localparam int PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntWidth = $clog2(DEPTH + 1);

   cmd_type               mem_ff [DEPTH];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]   cnt_ff, cnt_in;
   logic                  do_push;
   logic                  do_pop;

   assign q_full  = (cnt_ff == CntWidth'(DEPTH));
   assign q_empty = (cnt_ff == '0);
   assign head    = mem_ff[rd_ptr_ff];
   assign do_push = push_valid && !q_full;
   assign do_pop  = pop && !q_empty;

   // Advance pointers with wrap and track the fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({do_push, do_pop})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Store the pushed command
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// File: rtl/bfec_back.sv
// Back part of the codec: steps through the results of the head command,
// one response beat per cycle while rsp_ready is high, and pops the queue
// after the last one. Uses bfec_pkg.
`default_nettype none

module bfec_back import bfec_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    q_empty,
   input  wire cmd_type head,
   output logic         pop,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   logic [1:0] idx_ff, idx_in;
   logic       rsp_accept;
   logic       last_slot;

   assign rsp_valid  = !q_empty;
   assign rsp_data   = head.slots[idx_ff];
   assign rsp_accept = rsp_valid && rsp_ready;
   assign last_slot  = ({1'b0, idx_ff} + 3'd1) == head.count;
   assign pop        = rsp_accept && last_slot;

   // Advance through the slots; restart at the next command
   always_comb begin
      idx_in = idx_ff;
      if (rsp_accept) begin
         idx_in = last_slot ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 2'd0;
      end else begin
         idx_ff <= idx_in;
      end
   end

   // Slot index rests at zero while there is nothing to send
   assert property (@(posedge clock) disable iff (reset)
      q_empty |-> idx_ff == 2'd0)
      else $error("slot index nonzero with empty queue");

   // The head command has results and the index stays within them
   assert property (@(posedge clock) disable iff (reset)
      !q_empty |-> (head.count != '0) && (({1'b0, idx_ff}) < head.count))
      else $error("slot index outside head command");

   // A beat that is not the last of its command moves to the next slot
   assert property (@(posedge clock) disable iff (reset)
      (rsp_accept && !last_slot) |=> idx_ff == 2'($past(idx_ff) + 2'd1))
      else $error("slot index did not advance");

endmodule

`default_nettype wire

// File: rtl/brace_framed_escape_codec_unit.sv
// Top level of the brace-framed escape codec: front classifier, command queue
// and result sequencer. Uses bfec_pkg, bfec_front, bfec_queue and bfec_back.
//
//   channel  | direction | handshake          | beat
//   req_     | in        | req_valid/ready    | req_type: one byte with marks
//   rsp_     | out       | rsp_valid/ready    | rsp_type: one result
//   csr_     | in        | csr_wr_en          | direction bit, 0 encode 1 decode
//
// An item is classified in the cycle it is accepted; its results, up to four
// (an escaped byte gives two), leave one per cycle from the back part while
// rsp_ready is high. Items that give no result push nothing to the queue.
// The command queue of QUEUE_DEPTH entries lets the request side run on while
// the response side stalls. Reset clears direction, frame state and queue.
`default_nettype none

module brace_framed_escape_codec_unit import bfec_pkg::*; #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    csr_wr_en,
   input  wire logic    csr_wr_data,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   logic    q_full;
   logic    q_empty;
   logic    push_valid;
   cmd_type push_cmd;
   logic    pop;
   cmd_type head;

   bfec_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .q_full      (q_full),
      .push_valid  (push_valid),
      .push_cmd    (push_cmd)
   );

   bfec_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .q_full     (q_full),
      .pop        (pop),
      .q_empty    (q_empty),
      .head       (head)
   );

   bfec_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// File: dv/testbench.sv
// Self-checking testbench for brace_framed_escape_codec_unit: encodes and decodes framed
// byte strings under random stalls and checks every result beat against a local codec.
// Depends on bfec_pkg and the codec RTL only.
`timescale 1ns / 100ps

module testbench;
   import bfec_pkg::*;

   // Worst run: ~410 items, each up to four beats with a drawn stall after each
   // beat plus a drawn gap, and six settle pauses; the limit is several times that
   localparam int CycleLimit   = 400000;
   localparam int SettleCycles = 16;
   localparam int MaxReports   = 10;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    csr_wr_en   = 1'b0;
   logic    csr_wr_data = 1'b0;
   logic    req_valid   = 1'b0;
   logic    req_ready;
   req_type req_data    = '0;
   logic    rsp_valid;
   logic    rsp_ready   = 1'b0;
   rsp_type rsp_data;

   brace_framed_escape_codec_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Local codec state and the beats it still owes
   logic       dir_mode     = DirEncode;
   logic       esc_wait     = 1'b0;
   logic [1:0] frame_status = StatusOk;
   logic       frame_open   = 1'b0;
   rsp_type    codec_beats[$];
   req_type    byte_items[$];

   int   error_count  = 0;
   int   cycle_count  = 0;
   int   items_queued = 0;
   logic req_accepted = 1'b0;
   logic rsp_accepted = 1'b0;

   // Second byte of the escape pair for a byte, NoCode when it passes as is
   function automatic logic [7:0] stuffing_code(input logic [7:0] b);
      case (b)
         EscByte:   return CodeEsc;
         SpaceByte: return CodeSpace;
         LBrace:    return CodeLBrace;
         RBrace:    return CodeRBrace;
         default:   return NoCode;
      endcase
   endfunction

   function automatic void push_beat(input logic [7:0] b, input logic valid,
                                     input logic eof, input logic [1:0] st);
      rsp_type r;
      r.out_byte     = b;
      r.out_valid    = valid;
      r.end_of_frame = eof;
      r.status       = st;
      codec_beats.push_back(r);
   endfunction

   function automatic void keep_first_error(input logic [1:0] code);
      if (frame_status == StatusOk) frame_status = code;
   endfunction

   function automatic void clear_frame();
      esc_wait     = 1'b0;
      frame_status = StatusOk;
      frame_open   = 1'b0;
   endfunction

   // Advance the local codec by one accepted item
   function automatic void codec_step(input req_type it);
      logic [7:0] code;
      code = stuffing_code(it.in_byte);
      if (dir_mode == DirEncode) begin
         if (it.first) begin
            frame_open = 1'b1;
            push_beat(LBrace, 1'b1, 1'b0, StatusOk);
         end
         if (it.has_byte) begin
            if (code != NoCode) begin
               push_beat(EscByte, 1'b1, 1'b0, StatusOk);
               push_beat(code, 1'b1, 1'b0, StatusOk);
            end else begin
               push_beat(it.in_byte, 1'b1, 1'b0, StatusOk);
            end
         end
         if (it.last) begin
            push_beat(RBrace, 1'b1, 1'b1, StatusOk);
            frame_open = 1'b0;
         end
      end else begin
         if (it.first) begin
            clear_frame();
            frame_open = 1'b1;
            if (!it.has_byte || it.in_byte != LBrace) keep_first_error(StatusFrame);
         end else if (it.last) begin
            if (!frame_open) keep_first_error(StatusFrame);
         end else if (it.has_byte) begin
            // a content byte with no open frame opens one and flags the braces
            if (!frame_open) begin
               keep_first_error(StatusFrame);
               frame_open = 1'b1;
            end
            if (esc_wait) begin
               esc_wait = 1'b0;
               case (it.in_byte)
                  CodeEsc:    push_beat(EscByte, 1'b1, 1'b0, frame_status);
                  CodeSpace:  push_beat(SpaceByte, 1'b1, 1'b0, frame_status);
                  CodeLBrace: push_beat(LBrace, 1'b1, 1'b0, frame_status);
                  CodeRBrace: push_beat(RBrace, 1'b1, 1'b0, frame_status);
                  default:    keep_first_error(StatusEscape);
               endcase
            end else if (it.in_byte == EscByte) begin
               esc_wait = 1'b1;
            end else begin
               push_beat(it.in_byte, 1'b1, 1'b0, frame_status);
            end
         end
         // close the frame: one status beat, then back to the idle state
         if (it.last) begin
            if (it.first || !it.has_byte || it.in_byte != RBrace)
               keep_first_error(StatusFrame);
            if (esc_wait) keep_first_error(StatusEscape);
            push_beat('0, 1'b0, 1'b1, frame_status);
            clear_frame();
         end
      end
   endfunction

   function automatic void log_mismatch(input string what, input rsp_type want,
                                        input rsp_type got);
      error_count++;
      if (error_count <= MaxReports)
         $display("%0t %s: expected byte %02h valid %0d eof %0d status %0d,",
                  $time, what, want.out_byte, want.out_valid, want.end_of_frame,
                  want.status, "  got byte %02h valid %0d eof %0d status %0d",
                  got.out_byte, got.out_valid, got.end_of_frame, got.status);
   endfunction

   // Sample both channels and the register write at the rising edge
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         dir_mode = DirEncode;
         clear_frame();
         codec_beats.delete();
         req_accepted <= 1'b0;
         rsp_accepted <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            dir_mode = csr_wr_data;
            clear_frame();
         end
         if (req_valid && req_ready) codec_step(req_data);
         if (rsp_valid && rsp_ready) begin
            if (codec_beats.size() == 0) begin
               log_mismatch("beat with none pending", '0, rsp_data);
            end else begin
               want = codec_beats.pop_front();
               if (rsp_data !== want) log_mismatch("beat mismatch", want, rsp_data);
            end
         end
         req_accepted <= req_valid && req_ready;
         rsp_accepted <= rsp_valid && rsp_ready;
      end
   end

   // Request driver: hold each beat until taken, then idle a drawn gap
   int   req_gap     = 0;
   logic req_no_idle = 1'b0;
   always @(negedge clock) begin
      logic    next_valid;
      req_type next_data;
      next_valid = req_valid;
      next_data  = req_data;
      if (reset) begin
         next_valid = 1'b0;
      end else if (!req_valid || req_accepted) begin
         next_valid = 1'b0;
         if (req_gap > 0) begin
            req_gap--;
         end else if (byte_items.size() > 0) begin
            next_data  = byte_items.pop_front();
            next_valid = 1'b1;
            if ($urandom_range(0, 19) == 0) req_no_idle = !req_no_idle;
            req_gap = req_no_idle ? 0 : $urandom_range(0, 15);
         end
      end
      req_valid <= next_valid;
      req_data  <= next_data;
   end

   // Response side: stall a drawn number of cycles after each beat
   int   rsp_stall   = 0;
   logic rsp_no_idle = 1'b0;
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_accepted) begin
            if ($urandom_range(0, 19) == 0) rsp_no_idle = !rsp_no_idle;
            rsp_stall = rsp_no_idle ? 0 : $urandom_range(0, 15);
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic void send_item(input logic [7:0] b, input logic f, input logic l,
                                     input logic h);
      req_type it;
      it.in_byte  = b;
      it.first    = f;
      it.last     = l;
      it.has_byte = h;
      byte_items.push_back(it);
      items_queued++;
   endfunction

   // Half uniform bytes, half bytes that matter to the escape scheme
   function automatic logic [7:0] pick_byte();
      if ($urandom_range(0, 1)) return 8'($urandom_range(0, 255));
      case ($urandom_range(0, 5))
         0:       return EscByte;
         1:       return SpaceByte;
         2:       return LBrace;
         3:       return RBrace;
         4:       return CodeSpace;
         default: return CodeRBrace;
      endcase
   endfunction

   // Mostly whole strings, some empty strings and loose items
   task automatic encode_traffic(input int count);
      int stop;
      int len;
      stop = items_queued + count;
      while (items_queued < stop) begin
         case ($urandom_range(0, 9))
            0: send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            1: send_item(pick_byte(), 1'b1, 1'b1, 1'b0);
            default: begin
               len = $urandom_range(1, 6);
               for (int i = 0; i < len; i++)
                  send_item(pick_byte(), i == 0, i == len - 1, 1'b1);
            end
         endcase
      end
   endtask

   // Mostly well-formed frames; some with one spoiled beat, some loose items
   task automatic decode_traffic(input int count);
      logic [7:0] frame_bytes[$];
      logic [7:0] b;
      logic [7:0] code;
      logic       f;
      logic       l;
      logic       h;
      int         stop;
      int         len;
      int         spoil;
      int         flaw;
      stop = items_queued + count;
      while (items_queued < stop) begin
         if ($urandom_range(0, 9) == 0) begin
            send_item(pick_byte(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
         end else begin
            frame_bytes.delete();
            frame_bytes.push_back(LBrace);
            len = $urandom_range(0, 5);
            repeat (len) begin
               b    = pick_byte();
               code = stuffing_code(b);
               if (code != NoCode) begin
                  frame_bytes.push_back(EscByte);
                  frame_bytes.push_back(code);
               end else begin
                  frame_bytes.push_back(b);
               end
            end
            frame_bytes.push_back(RBrace);
            spoil = -1;
            if ($urandom_range(0, 4) == 0) spoil = $urandom_range(0, frame_bytes.size() - 1);
            flaw  = $urandom_range(0, 3);
            foreach (frame_bytes[i]) begin
               b = frame_bytes[i];
               f = (i == 0);
               l = (i == frame_bytes.size() - 1);
               h = 1'b1;
               if (i == spoil) begin
                  case (flaw)
                     0:       b = pick_byte();
                     1:       h = 1'b0;
                     2:       f = !f;
                     default: l = !l;
                  endcase
               end
               send_item(b, f, l, h);
            end
         end
      end
   endtask

   // Idle means nothing queued, nothing in flight, no beat owed, then settle
   task automatic wait_idle();
      while (byte_items.size() != 0 || req_valid || codec_beats.size() != 0)
         @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_direction(input logic value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Encode with the reset direction: all escaped bytes, empty string,
      // an item with no marks and no byte, a one-byte string
      send_item(8'h00, 1'b1, 1'b0, 1'b1);
      send_item(EscByte, 1'b0, 1'b0, 1'b1);
      send_item(SpaceByte, 1'b0, 1'b0, 1'b1);
      send_item(LBrace, 1'b0, 1'b0, 1'b1);
      send_item(RBrace, 1'b0, 1'b1, 1'b1);
      send_item(8'h5A, 1'b1, 1'b1, 1'b0);
      send_item(8'h33, 1'b0, 1'b0, 1'b0);
      send_item(8'hFF, 1'b1, 1'b1, 1'b1);
      wait_idle();

      // Decode: every escape code, bare braces as content, a byteless middle
      write_direction(DirDecode);
      send_item(LBrace, 1'b1, 1'b0, 1'b1);
      send_item(EscByte, 1'b0, 1'b0, 1'b1);
      send_item(CodeEsc, 1'b0, 1'b0, 1'b1);
      send_item(EscByte, 1'b0, 1'b0, 1'b1);
      send_item(CodeSpace, 1'b0, 1'b0, 1'b1);
      send_item(EscByte, 1'b0, 1'b0, 1'b1);
      send_item(CodeLBrace, 1'b0, 1'b0, 1'b1);
      send_item(EscByte, 1'b0, 1'b0, 1'b1);
      send_item(CodeRBrace, 1'b0, 1'b0, 1'b1);
      send_item(LBrace, 1'b0, 1'b0, 1'b1);
      send_item(RBrace, 1'b0, 1'b0, 1'b1);
      send_item(8'hFF, 1'b0, 1'b0, 1'b0);
      send_item(RBrace, 1'b0, 1'b1, 1'b1);
      // bad escape code, then an escape left open at the close
      send_item(LBrace, 1'b1, 1'b0, 1'b1);
      send_item(EscByte, 1'b0, 1'b0, 1'b1);
      send_item(8'h7A, 1'b0, 1'b0, 1'b1);
      send_item(EscByte, 1'b0, 1'b0, 1'b1);
      send_item(RBrace, 1'b0, 1'b1, 1'b1);
      // content outside a frame, close without a byte, open and close at once
      send_item(8'h41, 1'b0, 1'b0, 1'b1);
      send_item(8'h00, 1'b0, 1'b1, 1'b0);
      send_item(LBrace, 1'b1, 1'b1, 1'b1);
      wait_idle();

      write_direction(DirEncode);
      encode_traffic(90);
      wait_idle();
      write_direction(DirDecode);
      decode_traffic(100);
      wait_idle();
      // rewrite the same value: state clears, direction holds
      write_direction(DirDecode);
      decode_traffic(90);
      wait_idle();
      write_direction(DirEncode);
      encode_traffic(90);
      wait_idle();

      if (error_count == 0 && codec_beats.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
